// ===== src/fwsc_pkg.sv =====
// Shared types and constants for the word-sum frame receiver.
package fwsc_pkg;

  localparam int MIN_FRAME_LENGTH = 8;
  localparam int MAX_FRAME_LENGTH = 32;

  localparam logic [7:0] START_BYTE_RESET      = 8'hFE;
  localparam logic [7:0] STATION_ADDRESS_RESET = 8'h03;

  // Register select, taken from paddr[2]
  localparam logic REG_START_BYTE      = 1'b0;
  localparam logic REG_STATION_ADDRESS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_WRONG_DEST  = 2'd1,
    STATUS_BAD_SUM     = 2'd2,
    STATUS_BAD_LENGTH  = 2'd3
  } status_t;

  // What the back end has to do with one byte
  typedef enum logic [2:0] {
    KIND_START,
    KIND_LENGTH,
    KIND_BAD_LENGTH,
    KIND_BODY,
    KIND_SUM_HIGH,
    KIND_LAST
  } kind_t;

  // Header byte that must be captured, if any
  typedef enum logic [2:0] {
    FIELD_NONE,
    FIELD_ADDR,
    FIELD_CMD,
    FIELD_ARG1,
    FIELD_ARG2
  } field_t;

  typedef struct packed {
    kind_t      kind;
    field_t     field;
    logic       odd;
    logic [7:0] data;
    logic [7:0] length;
  } mid_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [7:0] length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] byte_position;
    logic [7:0] expected_length;
  } front_state_t;

endpackage

// ===== src/frame_receiver_word_sum_check.sv =====
// Length-prefixed frame receiver with 16-bit word-sum check, top level.
// Throughput: one byte per cycle sustained while results are popped.
// A frame's last byte passes through the byte queue, then the result queue, before its status
// reaches the result ports and can be popped.
// Reset (rst, synchronous) empties both queues, returns to hunting for the start byte
// and loads start_byte 0xFE and station_address 0x03.
module frame_receiver_word_sum_check #(
  parameter int MID_QUEUE_DEPTH = 4,
  parameter int OUT_QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  frame_status,
  output logic [7:0]  command_code,
  output logic [7:0]  first_argument,
  output logic [7:0]  second_argument,
  output logic [7:0]  frame_length
);
  import fwsc_pkg::*;

  logic [7:0]   start_byte;
  logic [7:0]   station_address;
  logic         cfg_write;

  logic         front_valid;
  mid_item_t    front_item;
  front_state_t front_state;
  logic         mid_full;
  logic         mid_empty;
  logic         mid_pop;
  mid_item_t    mid_item;
  logic         out_push;
  logic         out_full;
  out_item_t    back_item;
  out_item_t    head_item;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RESET;
      station_address <= STATION_ADDRESS_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_START_BYTE:      start_byte      <= pwdata[7:0];
        REG_STATION_ADDRESS: station_address <= pwdata[7:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_BYTE:      prdata = {24'h0, start_byte};
      REG_STATION_ADDRESS: prdata = {24'h0, station_address};
      default:             prdata = '0;
    endcase
  end

  fwsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start_byte  (start_byte),
    .push        (push),
    .rx_byte     (rx_byte),
    .q_full      (mid_full),
    .item_valid  (front_valid),
    .item        (front_item),
    .front_state (front_state)
  );

  assign full = mid_full;

  fwsc_queue #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_QUEUE_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_item),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_item),
    .empty     (mid_empty)
  );

  fwsc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .station_address (station_address),
    .mid_empty       (mid_empty),
    .mid_item        (mid_item),
    .mid_pop         (mid_pop),
    .out_full        (out_full),
    .out_push        (out_push),
    .out_item        (back_item)
  );

  fwsc_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (back_item),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (head_item),
    .empty     (empty)
  );

  assign frame_status    = head_item.status;
  assign command_code    = head_item.command;
  assign first_argument  = head_item.arg1;
  assign second_argument = head_item.arg2;
  assign frame_length    = head_item.length;

  // Position counter never runs past the longest legal frame
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    front_state.byte_position < 8'(MAX_FRAME_LENGTH))
    else $error("byte position beyond maximum frame length");

  // In the body of a frame the length is legal and not yet reached
  a_body_consistent: assert property (@(posedge clk) disable iff (rst)
    front_state.byte_position >= 8'd2 |->
      (front_state.expected_length >= 8'(MIN_FRAME_LENGTH) &&
       front_state.byte_position < front_state.expected_length))
    else $error("byte position inconsistent with frame length");

  // Back end never produces a result into a full result queue
  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (!out_full && mid_pop))
    else $error("result produced while result queue full");

  // A bad-length status always came straight from the length byte
  a_bad_length_start: assert property (@(posedge clk) disable iff (rst)
    (out_push && back_item.status == STATUS_BAD_LENGTH) |=>
      $past(mid_item.kind == KIND_BAD_LENGTH))
    else $error("bad-length status from wrong byte class");

endmodule

// ===== src/fwsc_queue.sv =====
// Small first-in first-out queue built from registers.
module fwsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/fwsc_front.sv =====
// Front end: tracks the byte position in the frame and classifies each byte.
module fwsc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             start_byte,
  input  logic                   push,
  input  logic [7:0]             rx_byte,
  input  logic                   q_full,
  output logic                   item_valid,
  output fwsc_pkg::mid_item_t    item,
  output fwsc_pkg::front_state_t front_state
);
  import fwsc_pkg::*;

  logic [7:0] byte_position;
  logic [7:0] byte_position_next;
  logic [7:0] expected_length;
  logic [7:0] expected_length_next;
  logic       accept;
  logic [8:0] pos_plus_two;

  assign accept       = push && !q_full;
  assign pos_plus_two = {1'b0, byte_position} + 9'd2;

  always_comb begin
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    item_valid           = 1'b0;
    item.kind            = KIND_BODY;
    item.field           = FIELD_NONE;
    item.odd             = byte_position[0];
    item.data            = rx_byte;
    item.length          = expected_length;

    if (byte_position == 8'd0) begin
      // hunt: drop everything but the start byte
      if (rx_byte == start_byte) begin
        item_valid         = accept;
        item.kind          = KIND_START;
        byte_position_next = 8'd1;
      end
    end else if (byte_position == 8'd1) begin
      item_valid  = accept;
      item.length = rx_byte;
      if (rx_byte < 8'(MIN_FRAME_LENGTH) || rx_byte > 8'(MAX_FRAME_LENGTH)) begin
        item.kind          = KIND_BAD_LENGTH;
        byte_position_next = 8'd0;
      end else begin
        item.kind            = KIND_LENGTH;
        expected_length_next = rx_byte;
        byte_position_next   = 8'd2;
      end
    end else begin
      item_valid = accept;
      case (byte_position)
        8'd2:    item.field = FIELD_ADDR;
        8'd5:    item.field = FIELD_CMD;
        8'd6:    item.field = FIELD_ARG1;
        8'd7:    item.field = FIELD_ARG2;
        default: item.field = FIELD_NONE;
      endcase
      if (pos_plus_two < {1'b0, expected_length}) begin
        item.kind          = KIND_BODY;
        byte_position_next = byte_position + 8'd1;
      end else if (pos_plus_two == {1'b0, expected_length}) begin
        item.kind          = KIND_SUM_HIGH;
        byte_position_next = byte_position + 8'd1;
      end else begin
        item.kind          = KIND_LAST;
        byte_position_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      expected_length <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      expected_length <= expected_length_next;
    end
  end

  assign front_state.byte_position   = byte_position;
  assign front_state.expected_length = expected_length;

endmodule

// ===== src/fwsc_back.sv =====
// Back end: keeps the word sum and header fields and builds the frame status.
module fwsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          station_address,
  input  logic                mid_empty,
  input  fwsc_pkg::mid_item_t mid_item,
  output logic                mid_pop,
  input  logic                out_full,
  output logic                out_push,
  output fwsc_pkg::out_item_t out_item
);
  import fwsc_pkg::*;

  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic        address_matched;
  logic        address_matched_next;
  logic [7:0]  saved_command;
  logic [7:0]  saved_command_next;
  logic [7:0]  saved_first_arg;
  logic [7:0]  saved_first_arg_next;
  logic [7:0]  saved_second_arg;
  logic [7:0]  saved_second_arg_next;
  logic [7:0]  received_sum_high;
  logic [7:0]  received_sum_high_next;
  logic [15:0] sum_term;
  logic        take;

  assign take     = !mid_empty && !out_full;
  assign mid_pop  = take;
  // even positions are the high byte of a word
  assign sum_term = mid_item.odd ? {8'h00, mid_item.data} : {mid_item.data, 8'h00};

  always_comb begin
    running_sum_next       = running_sum;
    address_matched_next   = address_matched;
    saved_command_next     = saved_command;
    saved_first_arg_next   = saved_first_arg;
    saved_second_arg_next  = saved_second_arg;
    received_sum_high_next = received_sum_high;
    out_push               = 1'b0;
    out_item.status        = STATUS_OK;
    out_item.command       = saved_command;
    out_item.arg1          = saved_first_arg;
    out_item.arg2          = saved_second_arg;
    out_item.length        = mid_item.length;

    case (mid_item.field)
      FIELD_ADDR: address_matched_next  = (mid_item.data == station_address);
      FIELD_CMD:  saved_command_next    = mid_item.data;
      FIELD_ARG1: saved_first_arg_next  = mid_item.data;
      FIELD_ARG2: saved_second_arg_next = mid_item.data;
      default:    ;
    endcase

    case (mid_item.kind)
      KIND_START: begin
        running_sum_next       = sum_term;
        address_matched_next   = 1'b0;
        saved_command_next     = '0;
        saved_first_arg_next   = '0;
        saved_second_arg_next  = '0;
        received_sum_high_next = '0;
      end
      KIND_LENGTH, KIND_BODY: begin
        running_sum_next = running_sum + sum_term;
      end
      KIND_SUM_HIGH: begin
        received_sum_high_next = mid_item.data;
      end
      KIND_BAD_LENGTH: begin
        out_push         = take;
        out_item.status  = STATUS_BAD_LENGTH;
        out_item.command = '0;
        out_item.arg1    = '0;
        out_item.arg2    = '0;
      end
      KIND_LAST: begin
        out_push      = take;
        out_item.arg2 = saved_second_arg_next;
        if (!address_matched) begin
          out_item.status = STATUS_WRONG_DEST;
        end else if ({received_sum_high, mid_item.data} != running_sum) begin
          out_item.status = STATUS_BAD_SUM;
        end else begin
          out_item.status = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      address_matched   <= 1'b0;
      saved_command     <= '0;
      saved_first_arg   <= '0;
      saved_second_arg  <= '0;
      received_sum_high <= '0;
    end else if (take) begin
      running_sum       <= running_sum_next;
      address_matched   <= address_matched_next;
      saved_command     <= saved_command_next;
      saved_first_arg   <= saved_first_arg_next;
      saved_second_arg  <= saved_second_arg_next;
      received_sum_high <= received_sum_high_next;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the word-sum frame receiver: phased byte stimulus, register setup, report checks.
module tb;
  import fwsc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_BYTES   = 230;
  localparam int STRESS_PIECES = 40;

  // Byte positions inside a frame
  localparam int POS_START  = 0;
  localparam int POS_LENGTH = 1;
  localparam int POS_DEST   = 2;
  localparam int POS_CMD    = 5;
  localparam int POS_ARG1   = 6;
  localparam int POS_ARG2   = 7;

  // How often a side idles between transactions
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  frame_status;
  logic [7:0]  command_code;
  logic [7:0]  first_argument;
  logic [7:0]  second_argument;
  logic [7:0]  frame_length;

  frame_receiver_word_sum_check dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .frame_status(frame_status), .command_code(command_code),
    .first_argument(first_argument), .second_argument(second_argument),
    .frame_length(frame_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and frame tracking state of the predictor
  logic [7:0]  start_mirror   = START_BYTE_RESET;
  logic [7:0]  station_mirror = STATION_ADDRESS_RESET;
  logic [7:0]  hunt_pos    = '0;
  logic [7:0]  frame_len   = '0;
  logic [15:0] word_sum    = '0;
  logic        dest_ok     = 1'b0;
  logic [7:0]  cmd_byte    = '0;
  logic [7:0]  arg1_byte   = '0;
  logic [7:0]  arg2_byte   = '0;
  logic [7:0]  sum_hi_byte = '0;

  logic [7:0]  byte_backlog[$];
  out_item_t   frame_reports_due[$];

  int unsigned send_mode = IDLE_LIGHT;
  int unsigned recv_mode = IDLE_LIGHT;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;

  int unsigned data_bytes = 0;
  int unsigned stall_cycles = 0;
  int unsigned reports_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  function automatic int unsigned draw_wait(input int unsigned mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got, input int unsigned want);
    mismatches++;
    $display("mismatch in report %0d: %s got %0h want %0h", reports_checked, what, got, want);
  endtask

  // Advance the frame tracker by one accepted byte; queue a report when a frame ends
  task automatic track_frame_byte(input logic [7:0] b);
    out_item_t rep;
    if (hunt_pos == POS_START) begin
      if (b == start_mirror) begin
        word_sum    = {b, 8'h00};
        dest_ok     = 1'b0;
        cmd_byte    = '0;
        arg1_byte   = '0;
        arg2_byte   = '0;
        sum_hi_byte = '0;
        frame_len   = '0;
        hunt_pos    = POS_LENGTH;
      end
    end else if (hunt_pos == POS_LENGTH) begin
      if (int'(b) < MIN_FRAME_LENGTH || int'(b) > MAX_FRAME_LENGTH) begin
        rep.status  = STATUS_BAD_LENGTH;
        rep.command = '0;
        rep.arg1    = '0;
        rep.arg2    = '0;
        rep.length  = b;
        frame_reports_due.push_back(rep);
        hunt_pos = POS_START;
      end else begin
        frame_len = b;
        word_sum  = word_sum + {8'h00, b};
        hunt_pos  = POS_DEST;
      end
    end else begin
      case (int'(hunt_pos))
        POS_DEST: dest_ok   = (b == station_mirror);
        POS_CMD:  cmd_byte  = b;
        POS_ARG1: arg1_byte = b;
        POS_ARG2: arg2_byte = b;
        default: ;
      endcase
      if (int'(hunt_pos) + 2 < int'(frame_len)) begin
        word_sum = word_sum + (hunt_pos[0] ? {8'h00, b} : {b, 8'h00});
        hunt_pos = hunt_pos + 8'd1;
      end else if (int'(hunt_pos) + 2 == int'(frame_len)) begin
        sum_hi_byte = b;
        hunt_pos = hunt_pos + 8'd1;
      end else begin
        // Wrong destination wins over a bad checksum
        if (!dest_ok) rep.status = STATUS_WRONG_DEST;
        else if ({sum_hi_byte, b} != word_sum) rep.status = STATUS_BAD_SUM;
        else rep.status = STATUS_OK;
        rep.command = cmd_byte;
        rep.arg1    = arg1_byte;
        rep.arg2    = arg2_byte;
        rep.length  = frame_len;
        frame_reports_due.push_back(rep);
        hunt_pos = POS_START;
      end
    end
  endtask

  always @(posedge clk) begin : byte_sender
    logic took;
    int unsigned wait_now;
    took = push && !full;
    if (rst) begin
      push <= 1'b0;
      send_wait <= 0;
    end else begin
      if (took) track_frame_byte(rx_byte);
      if (push && full) begin
        // hold the offered byte
        stall_cycles++;
      end else begin
        wait_now = took ? draw_wait(send_mode) : send_wait;
        if (wait_now != 0) begin
          push <= 1'b0;
          send_wait <= wait_now - 1;
        end else if (byte_backlog.size() != 0) begin
          push <= 1'b1;
          rx_byte <= byte_backlog.pop_front();
          send_wait <= 0;
        end else begin
          push <= 1'b0;
          send_wait <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin : report_checker
    logic took;
    int unsigned wait_now;
    out_item_t want;
    took = pop && !empty;
    if (rst) begin
      pop <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (took) begin
        if (frame_reports_due.size() == 0) begin
          note_mismatch("report with no frame pending, frame_status", frame_status, 0);
        end else begin
          want = frame_reports_due.pop_front();
          if (frame_status != want.status)
            note_mismatch("frame_status", frame_status, want.status);
          if (command_code != want.command)
            note_mismatch("command_code", command_code, want.command);
          if (first_argument != want.arg1)
            note_mismatch("first_argument", first_argument, want.arg1);
          if (second_argument != want.arg2)
            note_mismatch("second_argument", second_argument, want.arg2);
          if (frame_length != want.length)
            note_mismatch("frame_length", frame_length, want.length);
          status_seen[want.status]++;
        end
        reports_checked++;
      end
      if (stalls_served != stall_requests) begin
        // start a long hold-off so the block backs up into its input
        stalls_served++;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        wait_now = took ? draw_wait(recv_mode) : recv_wait;
        if (wait_now != 0) begin
          pop <= 1'b0;
          recv_wait <= wait_now - 1;
        end else begin
          pop <= 1'b1;
          recv_wait <= 0;
        end
      end
    end
  end

  task automatic write_register(input logic reg_sel, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_START_BYTE) start_mirror = value;
    else station_mirror = value;
    reg_writes++;
  endtask

  // Wait until every byte is taken and every report has come, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    while (byte_backlog.size() != 0 || push || frame_reports_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_bad_length(input logic [7:0] len);
    byte_backlog.push_back(start_mirror);
    byte_backlog.push_back(len);
    data_bytes += 2;
  endtask

  task automatic queue_frame(input int unsigned len, input logic [7:0] dest, input bit sum_good,
                             input logic [7:0] cmd, input logic [7:0] a1, input logic [7:0] a2,
                             input bit start_inside);
    logic [15:0] word_total;
    logic [7:0] v;
    int unsigned i;
    word_total = '0;
    for (i = 0; i + 2 < len; i++) begin
      case (int'(i))
        POS_START:  v = start_mirror;
        POS_LENGTH: v = len[7:0];
        POS_DEST:   v = dest;
        POS_CMD:    v = cmd;
        POS_ARG1:   v = a1;
        POS_ARG2:   v = a2;
        default: begin
          if ((start_inside && i == 3) || $urandom_range(0, 7) == 0) v = start_mirror;
          else v = 8'($urandom_range(0, 255));
        end
      endcase
      word_total = word_total + (i[0] ? {8'h00, v} : {v, 8'h00});
      byte_backlog.push_back(v);
    end
    if (!sum_good) word_total = word_total ^ (16'h1 << $urandom_range(0, 15));
    byte_backlog.push_back(word_total[15:8]);
    byte_backlog.push_back(word_total[7:0]);
    data_bytes += len;
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // line noise while hunting
      n = $urandom_range(1, 5);
      repeat (n) begin
        v = 8'($urandom_range(0, 255));
        if (v == start_mirror) v = v + 8'd1;
        byte_backlog.push_back(v);
      end
    end else if (pick < 16) begin
      if ($urandom_range(0, 1) == 0)
        queue_bad_length(8'($urandom_range(0, MIN_FRAME_LENGTH - 1)));
      else
        queue_bad_length(8'($urandom_range(MAX_FRAME_LENGTH + 1, 255)));
    end else if (pick < 22) begin
      // cut-off frame: whatever follows is taken as its body
      len = $urandom_range(MIN_FRAME_LENGTH, MAX_FRAME_LENGTH);
      n = $urandom_range(0, len - 3);
      byte_backlog.push_back(start_mirror);
      byte_backlog.push_back(len[7:0]);
      repeat (n) byte_backlog.push_back(8'($urandom_range(0, 255)));
      data_bytes += 2 + n;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = MIN_FRAME_LENGTH;
      else if (pick == 1) len = MAX_FRAME_LENGTH;
      else len = $urandom_range(MIN_FRAME_LENGTH + 1, 20);
      if ($urandom_range(0, 6) == 0) v = 8'($urandom_range(0, 255));
      else v = station_mirror;
      queue_frame(len, v, $urandom_range(0, 4) != 0, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    goal = data_bytes + count;
    while (data_bytes < goal) queue_random_frame();
  endtask

  initial begin : stimulus
    int phase;
    logic [7:0] new_start;
    logic [7:0] new_station;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: length limits, shortest frame, both faults with the start byte in the body
    byte_backlog.push_back(8'h55);
    queue_bad_length(8'h00);
    queue_bad_length(8'hFF);
    queue_bad_length(8'(MIN_FRAME_LENGTH - 1));
    queue_bad_length(8'(MAX_FRAME_LENGTH + 1));
    queue_frame(MIN_FRAME_LENGTH, station_mirror, 1'b1, 8'hFF, 8'h00, 8'h00, 1'b0);
    queue_frame(MIN_FRAME_LENGTH + 1, ~station_mirror, 1'b0, 8'h00, 8'hFF, 8'h80, 1'b1);
    run_random(PHASE_BYTES);
    settle();

    for (phase = 1; phase < 6; phase++) begin
      case (phase)
        1: begin
          new_start = 8'h00; new_station = 8'hFF;
          send_mode = IDLE_HEAVY; recv_mode = IDLE_NONE;
        end
        2: begin
          new_start = 8'hFF; new_station = 8'h00;
          send_mode = IDLE_NONE; recv_mode = IDLE_HEAVY;
        end
        3: begin
          new_start = 8'($urandom_range(0, 255)); new_station = 8'($urandom_range(0, 255));
          send_mode = IDLE_NONE; recv_mode = IDLE_NONE;
        end
        4: begin
          new_start = 8'($urandom_range(0, 255)); new_station = 8'($urandom_range(0, 255));
          send_mode = IDLE_HEAVY; recv_mode = IDLE_HEAVY;
        end
        default: begin
          new_start = START_BYTE_RESET; new_station = STATION_ADDRESS_RESET;
          send_mode = IDLE_LIGHT; recv_mode = IDLE_LIGHT;
        end
      endcase
      write_register(REG_START_BYTE, new_start);
      write_register(REG_STATION_ADDRESS, new_station);
      @(negedge clk);
      if (phase == 3) begin
        // dense short reports while the reader holds off
        stall_requests++;
        repeat (STRESS_PIECES) begin
          if ($urandom_range(0, 1) == 0)
            queue_bad_length(8'($urandom_range(0, MIN_FRAME_LENGTH - 1)));
          else
            queue_frame(MIN_FRAME_LENGTH, station_mirror, $urandom_range(0, 3) != 0,
                        8'($urandom_range(0, 255)), 8'h00, 8'h00, 1'b0);
        end
      end else begin
        run_random(PHASE_BYTES);
      end
      settle();
    end

    $display("run covered %0d frame bytes and %0d reports: ok %0d, wrong dest %0d,",
             data_bytes, reports_checked, status_seen[STATUS_OK], status_seen[STATUS_WRONG_DEST]);
    $display("bad sum %0d, bad length %0d, %0d register writes, %0d cycles with input held off",
             status_seen[STATUS_BAD_SUM], status_seen[STATUS_BAD_LENGTH], reg_writes,
             stall_cycles);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles, %0d reports still pending",
             QUIET_LIMIT, frame_reports_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
